FILE: rtl/tfd_pkg.sv
// shared types and constants for the typed frame deframer
package tfd_pkg;

	localparam logic [7:0] START_BYTE = 8'hff;
	localparam logic [7:0] END_BYTE   = 8'h00;

	localparam int CFG_IDX_W = 3;
	localparam int NUM_CODES = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_BOOL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOAT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_UINT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ULONG = 3'd6;

	localparam logic [1:0] KIND_COUNT   = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;

	// last byte position of a field: length minus one
	localparam logic [1:0] LAST_LEN1 = 2'd0;
	localparam logic [1:0] LAST_LEN2 = 2'd1;
	localparam logic [1:0] LAST_LEN4 = 2'd3;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_COUNT = 3'd1,
		PH_TYPES = 3'd2,
		PH_DATA  = 3'd3,
		PH_END   = 3'd4
	} phase_t;

	typedef logic [NUM_CODES-1:0][7:0] code_regs_t;

	typedef struct packed {
		logic       known;
		logic [1:0] last;
	} type_info_t;

	typedef struct packed {
		logic [7:0] idx;
		logic [1:0] last;
	} field_entry_t;

endpackage

FILE: rtl/tfd_if.sv
// request channel interfaces: received bytes in, deframed results out
interface tfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfd_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] out_kind;
	logic [7:0] field_index;
	logic [1:0] byte_in_field;
	logic       frame_ok;
	logic       frame_last;

	modport source (
		output valid, output out_byte, output out_kind, output field_index,
		output byte_in_field, output frame_ok, output frame_last, input ready
	);
	modport sink (
		input valid, input out_byte, input out_kind, input field_index,
		input byte_in_field, input frame_ok, input frame_last, output ready
	);
endinterface

FILE: rtl/tfd_type_decode.sv
// type code to field length lookup against the programmed code registers
module tfd_type_decode (
	input  logic [7:0]          code,
	input  tfd_pkg::code_regs_t codes,
	output tfd_pkg::type_info_t info
);
	import tfd_pkg::*;

	always_comb begin
		info.known = 1'b1;
		info.last  = LAST_LEN1;
		if (code == codes[CFG_BOOL] || code == codes[CFG_BYTE]) begin
			info.last = LAST_LEN1;
		end else if (code == codes[CFG_INT]) begin
			info.last = LAST_LEN2;
		end else if (code == codes[CFG_LONG] || code == codes[CFG_FLOAT]) begin
			info.last = LAST_LEN4;
		end else if (code == codes[CFG_UINT]) begin
			info.last = LAST_LEN2;
		end else if (code == codes[CFG_ULONG]) begin
			info.last = LAST_LEN4;
		end else begin
			info.known = 1'b0;
		end
	end

endmodule

FILE: rtl/typed_frame_deframer.sv
// typed frame deframer top level
//
//  channel | dir | payload                                             | handshake
//  rx      | in  | rx_byte                                             | valid/ready
//  res     | out | out_byte out_kind field_index byte_in_field ok last | valid/ready
//  cfg     | in  | cfg_index cfg_wdata                                 | cfg_we
//
//  one byte per cycle while res is drained: each request is handled in the cycle it is taken
//  a result appears on res in the cycle after its request and sits in the output register
//  a new request is taken whenever the output register is empty or being drained
//  only fields with a nonzero length are queued, so the data phase never has to skip a field
//  reset clears phase and counters, presets codes; the field queue memory needs no clearing
module typed_frame_deframer #(
	parameter int MAX_FIELDS = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tfd_rx_if.sink                         rx,
	tfd_res_if.source                      res,
	input  logic                           cfg_we,
	input  logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                     cfg_wdata
);
	import tfd_pkg::*;

	localparam int AW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
	localparam logic [8:0] MAX_N = 9'(MAX_FIELDS);

	phase_t       phase_q, phase_d;
	logic [8:0]   n_q, n_d;
	logic [8:0]   tc_q, tc_d;
	logic [8:0]   nz_q, nz_d;
	logic [8:0]   k_q, k_d;
	logic [8:0]   ptr_q, ptr_d;
	logic [1:0]   bc_q, bc_d;
	logic         good_q, good_d;
	field_entry_t cur_q, cur_d, nxt_q, nxt_d, rdata_q, wr_entry;
	logic         wr_en;
	code_regs_t   codes_q;
	type_info_t   tinfo;

	field_entry_t mem [MAX_FIELDS];

	logic         accept, emit;
	logic [7:0]   o_byte_d, o_idx_d;
	logic [1:0]   o_kind_d, o_pos_d;
	logic         o_ok_d, o_last_d;
	logic         res_valid_q;

	assign rx.ready  = !res_valid_q || res.ready;
	assign accept    = rx.valid && rx.ready;
	assign res.valid = res_valid_q;

	tfd_type_decode u_decode (
		.code  (rx.rx_byte),
		.codes (codes_q),
		.info  (tinfo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q[CFG_BOOL]  <= 8'd0;
			codes_q[CFG_BYTE]  <= 8'd1;
			codes_q[CFG_INT]   <= 8'd2;
			codes_q[CFG_LONG]  <= 8'd3;
			codes_q[CFG_FLOAT] <= 8'd4;
			codes_q[CFG_UINT]  <= 8'd5;
			codes_q[CFG_ULONG] <= 8'd6;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BOOL:  codes_q[CFG_BOOL]  <= cfg_wdata;
				CFG_BYTE:  codes_q[CFG_BYTE]  <= cfg_wdata;
				CFG_INT:   codes_q[CFG_INT]   <= cfg_wdata;
				CFG_LONG:  codes_q[CFG_LONG]  <= cfg_wdata;
				CFG_FLOAT: codes_q[CFG_FLOAT] <= cfg_wdata;
				CFG_UINT:  codes_q[CFG_UINT]  <= cfg_wdata;
				CFG_ULONG: codes_q[CFG_ULONG] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d  = phase_q;
		n_d      = n_q;
		tc_d     = tc_q;
		nz_d     = nz_q;
		k_d      = k_q;
		ptr_d    = ptr_q;
		bc_d     = bc_q;
		good_d   = good_q;
		cur_d    = cur_q;
		nxt_d    = nxt_q;
		wr_en    = 1'b0;
		wr_entry = '{idx: tc_q[7:0], last: tinfo.last};
		emit     = 1'b0;
		o_byte_d = rx.rx_byte;
		o_kind_d = KIND_COUNT;
		o_idx_d  = 8'd0;
		o_pos_d  = 2'd0;
		o_ok_d   = 1'b0;
		o_last_d = 1'b0;
		if (accept) begin
			unique case (phase_q)
				PH_COUNT: begin
					n_d    = ({1'b0, rx.rx_byte} > MAX_N) ? MAX_N : {1'b0, rx.rx_byte};
					tc_d   = 9'd0;
					nz_d   = 9'd0;
					good_d = 1'b1;
					ptr_d  = 9'd2;
					phase_d = (n_d == 9'd0) ? PH_END : PH_TYPES;
					emit   = 1'b1;
				end
				PH_TYPES: begin
					if (!tinfo.known) begin
						good_d = 1'b0;
					end else begin
						wr_en = 1'b1;
						nz_d  = nz_q + 9'd1;
						if (nz_q == 9'd0) begin
							cur_d = wr_entry;
						end
						if (nz_q == 9'd1) begin
							nxt_d = wr_entry;
						end
					end
					tc_d = tc_q + 9'd1;
					if (tc_d >= n_q) begin
						k_d     = 9'd0;
						bc_d    = 2'd0;
						phase_d = (nz_d != 9'd0) ? PH_DATA : PH_END;
					end
				end
				PH_DATA: begin
					emit     = 1'b1;
					o_kind_d = KIND_PAYLOAD;
					o_idx_d  = cur_q.idx;
					o_pos_d  = bc_q;
					if (bc_q == cur_q.last) begin
						bc_d = 2'd0;
						if (k_q + 9'd1 < nz_q) begin
							k_d   = k_q + 9'd1;
							cur_d = nxt_q;
							nxt_d = rdata_q;
							ptr_d = ptr_q + 9'd1;
						end else begin
							phase_d = PH_END;
						end
					end else begin
						bc_d = bc_q + 2'd1;
					end
				end
				PH_END: begin
					emit     = 1'b1;
					o_kind_d = KIND_END;
					o_ok_d   = good_q && (rx.rx_byte == END_BYTE);
					o_last_d = 1'b1;
					phase_d  = PH_HUNT;
				end
				default: begin
					phase_d = (rx.rx_byte == START_BYTE) ? PH_COUNT : PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			n_q         <= 9'd0;
			tc_q        <= 9'd0;
			nz_q        <= 9'd0;
			k_q         <= 9'd0;
			ptr_q       <= 9'd2;
			bc_q        <= 2'd0;
			good_q      <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			n_q     <= n_d;
			tc_q    <= tc_d;
			nz_q    <= nz_d;
			k_q     <= k_d;
			ptr_q   <= ptr_d;
			bc_q    <= bc_d;
			good_q  <= good_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		nxt_q <= nxt_d;
		if (emit) begin
			res.out_byte      <= o_byte_d;
			res.out_kind      <= o_kind_d;
			res.field_index   <= o_idx_d;
			res.byte_in_field <= o_pos_d;
			res.frame_ok      <= o_ok_d;
			res.frame_last    <= o_last_d;
		end
	end

	// queue of nonzero-length fields; read data tracks the entry at ptr_q
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[nz_q[AW-1:0]] <= wr_entry;
		end
		if (wr_en && (nz_q[AW-1:0] == ptr_d[AW-1:0])) begin
			rdata_q <= wr_entry;
		end else begin
			rdata_q <= mem[ptr_d[AW-1:0]];
		end
	end

endmodule

FILE: rtl/tfd_checker.sv
// port-level assertions for the typed frame deframer, bound to the top level
module tfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_valid,
	input logic       rx_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] out_byte,
	input logic [1:0] out_kind,
	input logic [7:0] field_index,
	input logic [1:0] byte_in_field,
	input logic       frame_ok,
	input logic       frame_last
);
	import tfd_pkg::*;

	// result valid, byte and kind held while stalled
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_byte) && $stable(out_kind))
		else $error("result changed while stalled");

	// free output register never blocks a request
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> rx_ready)
		else $error("request blocked with empty output");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (frame_last == (out_kind == KIND_END)))
		else $error("frame_last does not match end kind");

	a_ok_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_ok |-> frame_last)
		else $error("frame_ok outside end of frame");

	a_pos_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (out_kind != KIND_PAYLOAD) |-> (field_index == 8'd0) &&
			(byte_in_field == 2'd0))
		else $error("field position on a non-payload result");

endmodule

bind typed_frame_deframer tfd_checker u_tfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rx_valid      (rx.valid),
	.rx_ready      (rx.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.out_byte      (res.out_byte),
	.out_kind      (res.out_kind),
	.field_index   (res.field_index),
	.byte_in_field (res.byte_in_field),
	.frame_ok      (res.frame_ok),
	.frame_last    (res.frame_last)
);

FILE: sim/typed_frame_deframer_tb.sv
// self-checking testbench for the typed frame deframer: random frames, codes and stalls
`timescale 1ns / 1ps

module typed_frame_deframer_tb;
	import tfd_pkg::*;

	localparam int LIMIT = 200000;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic [7:0] idx;
		logic [1:0] pos;
		logic       ok;
		logic       last;
	} result_t;

	class deframe_scoreboard;
		code_regs_t codes;
		phase_t     phase;
		logic [7:0] nfields;
		logic [2:0] lens [256];
		logic [8:0] fcnt;
		logic [1:0] bcnt;
		logic       good;
		result_t    expected_results [$];
		int         errors, results, frames, good_frames;

		function new();
			for (int i = 0; i < NUM_CODES; i++) codes[i] = 8'(i);
			phase = PH_HUNT;
			nfields = '0;
			fcnt = '0;
			bcnt = '0;
			good = 1'b1;
		endfunction

		function logic [2:0] code_length(input logic [7:0] c, output logic known);
			known = 1'b1;
			if (c == codes[CFG_BOOL] || c == codes[CFG_BYTE]) return 3'd1;
			if (c == codes[CFG_INT]) return 3'd2;
			if (c == codes[CFG_LONG] || c == codes[CFG_FLOAT]) return 3'd4;
			if (c == codes[CFG_UINT]) return 3'd2;
			if (c == codes[CFG_ULONG]) return 3'd4;
			known = 1'b0;
			return 3'd0;
		endfunction

		// skip fields with no data bytes
		function void seek_field();
			while (fcnt < {1'b0, nfields} && lens[fcnt[7:0]] == 3'd0) fcnt++;
			bcnt = '0;
			phase = (fcnt < {1'b0, nfields}) ? PH_DATA : PH_END;
		endfunction

		function void take_rx_byte(input logic [7:0] b);
			result_t r;
			logic known;
			r = '0;
			case (phase)
				PH_COUNT: begin
					nfields = b;
					fcnt = '0;
					bcnt = '0;
					good = 1'b1;
					phase = (b == 8'd0) ? PH_END : PH_TYPES;
					r.out_byte = b;
					r.kind = KIND_COUNT;
					expected_results.push_back(r);
				end
				PH_TYPES: begin
					lens[fcnt[7:0]] = code_length(b, known);
					if (!known) good = 1'b0;
					fcnt++;
					if (fcnt >= {1'b0, nfields}) begin
						fcnt = '0;
						seek_field();
					end
				end
				PH_DATA: begin
					r.out_byte = b;
					r.kind = KIND_PAYLOAD;
					r.idx = fcnt[7:0];
					r.pos = bcnt;
					bcnt++;
					if (int'(r.pos) + 1 >= int'(lens[fcnt[7:0]])) begin
						fcnt++;
						seek_field();
					end
					expected_results.push_back(r);
				end
				PH_END: begin
					r.out_byte = b;
					r.kind = KIND_END;
					r.ok = good && b == END_BYTE;
					r.last = 1'b1;
					phase = PH_HUNT;
					fcnt = '0;
					bcnt = '0;
					frames++;
					if (r.ok) good_frames++;
					expected_results.push_back(r);
				end
				default: phase = (b == START_BYTE) ? PH_COUNT : PH_HUNT;
			endcase
		endfunction

		function void compare(input string name, input int exp_v, input int got_v);
			if (exp_v != got_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(input result_t got);
			result_t e;
			results++;
			if (expected_results.size() == 0) begin
				$error("unexpected result: out_byte %0d kind %0d", got.out_byte, got.kind);
				errors++;
				return;
			end
			e = expected_results.pop_front();
			compare("out_byte", int'(e.out_byte), int'(got.out_byte));
			compare("out_kind", int'(e.kind), int'(got.kind));
			compare("field_index", int'(e.idx), int'(got.idx));
			compare("byte_in_field", int'(e.pos), int'(got.pos));
			compare("frame_ok", int'(e.ok), int'(got.ok));
			compare("frame_last", int'(e.last), int'(got.last));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_wdata;
	logic                 sink_ready = 1'b0;
	bit                   steady = 1'b0;
	int                   sent = 0;
	int                   settings = 0;
	int                   cycles = 0;
	deframe_scoreboard    sb = new();

	tfd_rx_if  rx_ch ();
	tfd_res_if res_ch ();

	assign res_ch.ready = sink_ready;

	typed_frame_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		sink_ready <= steady || $urandom_range(0, 99) >= 27;
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result(result_t'({res_ch.out_byte, res_ch.out_kind, res_ch.field_index,
				res_ch.byte_in_field, res_ch.frame_ok, res_ch.frame_last}));
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while (!steady && $urandom_range(0, 99) < 27) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		sb.take_rx_byte(b);
		sent++;
		@(negedge clk);
	endtask

	// hold the sender until every result is back, then let the block settle
	task automatic wait_idle();
		rx_ch.valid <= 1'b0;
		while (sb.expected_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_codes(input code_regs_t v);
		for (int i = 0; i < NUM_CODES; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_wdata <= v[i];
			@(posedge clk);
			sb.codes[i] = v[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic send_frame(input int count, input int known_pct, input bit last_known,
		input bit bad_end);
		int lens [256];
		logic known;
		logic [7:0] code;
		send_byte(START_BYTE);
		send_byte(8'(count));
		for (int i = 0; i < count; i++) begin
			if ((last_known && i == count - 1) || $urandom_range(0, 99) < known_pct)
				code = sb.codes[$urandom_range(0, NUM_CODES - 1)];
			else
				code = 8'($urandom_range(0, 255));
			lens[i] = int'(sb.code_length(code, known));
			send_byte(code);
		end
		for (int i = 0; i < count; i++)
			for (int k = 0; k < lens[i]; k++) send_byte(8'($urandom_range(0, 255)));
		send_byte(bad_end ? 8'($urandom_range(1, 255)) : END_BYTE);
	endtask

	task automatic random_frames(input int n);
		int stop;
		int pick;
		stop = sent + n;
		while (sent < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 80)
				send_frame(($urandom_range(0, 99) < 80) ? $urandom_range(1, 5)
					: $urandom_range(0, 24), 85, 1'b0, $urandom_range(0, 99) < 10);
			else if (pick < 90)
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 254)));
			else
				send_frame($urandom_range(1, 6), 30, 1'b0, $urandom_range(0, 1) == 1);
		end
	endtask

	initial begin
		code_regs_t cset;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// noise while hunting, then bool, int and ulong fields
		send_byte(8'h00); send_byte(8'h7e);
		send_byte(START_BYTE); send_byte(8'd3);
		send_byte(sb.codes[CFG_BOOL]); send_byte(sb.codes[CFG_INT]);
		send_byte(sb.codes[CFG_ULONG]);
		send_byte(8'h80); send_byte(8'h34); send_byte(8'h12);
		send_byte(8'hff); send_byte(8'hfe); send_byte(8'h01); send_byte(8'h7f);
		send_byte(END_BYTE);
		// unknown code, start byte as data, bad end byte
		send_byte(START_BYTE); send_byte(8'd2); send_byte(8'h99);
		send_byte(sb.codes[CFG_FLOAT]);
		send_byte(START_BYTE); send_byte(8'h00); send_byte(8'h55); send_byte(8'haa);
		send_byte(8'h5a);
		// empty frame, then a frame whose only field has no data
		send_byte(START_BYTE); send_byte(8'd0); send_byte(END_BYTE);
		send_byte(START_BYTE); send_byte(8'd1); send_byte(8'hee); send_byte(END_BYTE);

		random_frames(30);
		wait_idle();

		// extreme codes, several shared so the first match decides
		cset[CFG_BOOL] = 8'hff;
		cset[CFG_BYTE] = 8'h00;
		cset[CFG_INT] = 8'h00;
		cset[CFG_LONG] = 8'hff;
		cset[CFG_FLOAT] = 8'h80;
		cset[CFG_UINT] = 8'h7f;
		cset[CFG_ULONG] = 8'h80;
		load_codes(cset);
		random_frames(25);
		wait_idle();

		for (int i = 0; i < NUM_CODES; i++) cset[i] = 8'($urandom_range(0, 255));
		load_codes(cset);
		steady = 1'b1;
		random_frames(40);
		steady = 1'b0;
		send_frame(255, 4, 1'b1, 1'b0);
		random_frames(15);
		wait_idle();

		for (int i = 0; i < NUM_CODES; i++) cset[i] = 8'($urandom_range(0, 255));
		load_codes(cset);
		random_frames(20);
		wait_idle();
		repeat (10) @(negedge clk);

		$display("sent %0d bytes over %0d code settings; checked %0d results", sent,
			settings + 1, sb.results);
		$display("closed %0d frames, %0d of them good", sb.frames, sb.good_frames);
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
